// ===== sv/grey_neighbour_max_diff_edges_top_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the grey neighbour contour block
// Concurrent property wrappers sampled on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef GREY_NEIGHBOUR_MAX_DIFF_EDGES_TOP_DEFINES_SVH
`define GREY_NEIGHBOUR_MAX_DIFF_EDGES_TOP_DEFINES_SVH

// same-cycle implication
`define GNMD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define GNMD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/gnmd_pkg.sv =====
// ----------------------------------------------------------------------------
// gnmd_pkg
// Shared types and constants of the grey neighbour contour block.
// ----------------------------------------------------------------------------
package gnmd_pkg;

    localparam int PIX_W       = 8;
    localparam int PIX_MAX     = 255;
    localparam int IMG_W_BITS  = 12;
    localparam int IMG_H_BITS  = 13;
    localparam int ROW_W       = 13;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 13;

    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = CFG_INDEX_W'(1);

    localparam int WIDTH_RESET  = 640;
    localparam int HEIGHT_RESET = 480;
    localparam int HEIGHT_MAX   = 4096;

    // grey = floor((30 R + 59 G + 11 B) / 100), division by reciprocal
    localparam int W_RED       = 30;
    localparam int W_GREEN     = 59;
    localparam int W_BLUE      = 11;
    localparam int SUM_W       = 15;
    localparam int RECIP       = 5243;
    localparam int RECIP_W     = 13;
    localparam int RECIP_SHIFT = 19;

    localparam int FIFO_DEPTH = 8;

    typedef logic [PIX_W-1:0] pix_t;
    typedef pix_t [2:0][2:0] win_t;

    typedef struct packed {
        logic have;
        logic eof;
        logic top;
        logic bottom;
        logic left;
        logic right;
    } pos_t;

    typedef struct packed {
        pix_t contour;
        logic eof;
    } res_t;

endpackage

// ===== sv/gnmd_ram.sv =====
// ----------------------------------------------------------------------------
// gnmd_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module gnmd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/gnmd_scan.sv =====
// ----------------------------------------------------------------------------
// gnmd_scan
// Frame size registers, raster column/row counters and centre position flags.
// ----------------------------------------------------------------------------
module gnmd_scan #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    input  logic [gnmd_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [gnmd_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic                                cfg_ready,
    input  logic                                advance,
    output logic [$clog2(MAX_WIDTH)-1:0]        addr,
    output gnmd_pkg::pos_t                      pos
);

    import gnmd_pkg::*;

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int W_RST = (WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET;

    logic [CW-1:0]    w_m1_reg, w_m1_next;
    logic [ROW_W-1:0] h_eff_reg, h_eff_next;
    logic [ROW_W-1:0] h_m1_reg, h_m1_next;
    logic [CW-1:0]    col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;

    logic [31:0]      wv;
    logic [ROW_W-1:0] hv;
    logic [CW-1:0]    cx;
    logic [ROW_W-1:0] cy;
    logic             col_nz;
    logic             have_raw;
    logic             in_frame;

    assign cfg_ready = 1'b1;
    assign wv        = 32'(cfg_data[IMG_W_BITS-1:0]);
    assign hv        = ROW_W'(cfg_data[IMG_H_BITS-1:0]);

    always_comb
    begin
        w_m1_next  = w_m1_reg;
        h_eff_next = h_eff_reg;
        h_m1_next  = h_m1_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:
                begin
                    if (wv == 32'd0)
                        w_m1_next = '0;
                    else if (wv > 32'(MAX_WIDTH))
                        w_m1_next = CW'(MAX_WIDTH - 1);
                    else
                        w_m1_next = CW'(wv - 32'd1);
                end
                REG_IMAGE_HEIGHT:
                begin
                    if (hv == '0)
                        h_eff_next = ROW_W'(1);
                    else if (hv > ROW_W'(HEIGHT_MAX))
                        h_eff_next = ROW_W'(HEIGHT_MAX);
                    else
                        h_eff_next = hv;
                    h_m1_next = h_eff_next - ROW_W'(1);
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        col_nz   = (col_reg != '0);
        cx       = col_nz ? (col_reg - CW'(1)) : w_m1_reg;
        cy       = col_nz ? (row_reg - ROW_W'(1)) : (row_reg - ROW_W'(2));
        have_raw = col_nz ? (row_reg != '0) : (row_reg >= ROW_W'(2));
        in_frame = have_raw && (cx <= w_m1_reg) && (cy <= h_m1_reg);

        pos.have   = in_frame;
        pos.eof    = in_frame && (cx == w_m1_reg) && (cy == h_m1_reg);
        pos.top    = (cy == '0);
        pos.bottom = (cy >= h_m1_reg);
        pos.left   = (cx == '0);
        pos.right  = (cx >= w_m1_reg);
    end

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (advance)
        begin
            if (pos.eof)
            begin
                col_next = '0;
                row_next = '0;
            end
            else if (col_reg >= w_m1_reg)
            begin
                col_next = '0;
                row_next = (row_reg > h_eff_reg) ? '0 : (row_reg + ROW_W'(1));
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_m1_reg  <= CW'(W_RST - 1);
            h_eff_reg <= ROW_W'(HEIGHT_RESET);
            h_m1_reg  <= ROW_W'(HEIGHT_RESET - 1);
            col_reg   <= '0;
            row_reg   <= '0;
        end
        else
        begin
            w_m1_reg  <= w_m1_next;
            h_eff_reg <= h_eff_next;
            h_m1_reg  <= h_m1_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
        end
    end

    assign addr = col_reg;

endmodule

// ===== sv/gnmd_line_buf.sv =====
// ----------------------------------------------------------------------------
// gnmd_line_buf
// Grey conversion, two-row line memory read-modify-write and 3x3 window.
// ----------------------------------------------------------------------------
module gnmd_line_buf #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          advance,
    input  logic [gnmd_pkg::PIX_W-1:0]    red,
    input  logic [gnmd_pkg::PIX_W-1:0]    green,
    input  logic [gnmd_pkg::PIX_W-1:0]    blue,
    input  logic                          is_padding,
    input  logic [$clog2(MAX_WIDTH)-1:0]  addr,
    input  gnmd_pkg::pos_t                pos,
    output logic                          s4_valid,
    output gnmd_pkg::pos_t                s4_pos,
    output gnmd_pkg::win_t                win
);

    import gnmd_pkg::*;

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int ENT_W = 2 * PIX_W;
    localparam int PRD_W = SUM_W + RECIP_W;

    logic             s1_valid_reg;
    pix_t             s1_red_reg, s1_green_reg, s1_blue_reg;
    logic             s1_pad_reg;
    logic [CW-1:0]    s1_addr_reg;
    pos_t             s1_pos_reg;

    logic             s2_valid_reg;
    logic [SUM_W-1:0] s2_sum_reg, s2_sum_next;
    logic [CW-1:0]    s2_addr_reg;
    pos_t             s2_pos_reg;

    logic             s3_valid_reg;
    pix_t             s3_grey_reg, s3_grey_next;
    logic [CW-1:0]    s3_addr_reg;
    pos_t             s3_pos_reg;
    logic             s3_fwd_reg, s3_fwd_next;
    logic [ENT_W-1:0] fwd_data_reg;

    logic             s4_valid_reg;
    pos_t             s4_pos_reg;
    win_t             win_reg, win_next;

    logic [PRD_W-1:0] prod;
    logic [ENT_W-1:0] rd_data;
    logic [ENT_W-1:0] entry;
    logic [ENT_W-1:0] wr_data;
    pix_t             up;
    pix_t             mid;

    assign s2_sum_next = s1_pad_reg ? '0 :
                         SUM_W'(W_RED * int'(s1_red_reg) + W_GREEN * int'(s1_green_reg)
                                + W_BLUE * int'(s1_blue_reg));

    assign prod         = PRD_W'(s2_sum_reg) * PRD_W'(RECIP);
    assign s3_grey_next = prod[RECIP_SHIFT +: PIX_W];

    assign s3_fwd_next = s2_valid_reg && s3_valid_reg && (s2_addr_reg == s3_addr_reg);

    gnmd_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_WIDTH)
    ) u_ram (
        .clk   (clk),
        .we    (s3_valid_reg),
        .waddr (s3_addr_reg),
        .wdata (wr_data),
        .re    (s2_valid_reg),
        .raddr (s2_addr_reg),
        .rdata (rd_data)
    );

    // entry layout: older row in the upper byte, newer row in the lower byte
    assign entry   = s3_fwd_reg ? fwd_data_reg : rd_data;
    assign up      = entry[ENT_W-1:PIX_W];
    assign mid     = entry[PIX_W-1:0];
    assign wr_data = {mid, s3_grey_reg};

    always_comb
    begin
        win_next = win_reg;
        if (s3_valid_reg)
        begin
            for (int i = 0; i < 3; i++)
            begin
                win_next[i][0] = win_reg[i][1];
                win_next[i][1] = win_reg[i][2];
            end
            win_next[0][2] = up;
            win_next[1][2] = mid;
            win_next[2][2] = s3_grey_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s3_fwd_reg   <= 1'b0;
            win_reg      <= '0;
        end
        else
        begin
            s1_valid_reg <= advance;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s3_fwd_reg   <= s3_fwd_next;
            win_reg      <= win_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_red_reg   <= red;
            s1_green_reg <= green;
            s1_blue_reg  <= blue;
            s1_pad_reg   <= is_padding;
            s1_addr_reg  <= addr;
            s1_pos_reg   <= pos;
        end
        if (s1_valid_reg)
        begin
            s2_sum_reg  <= s2_sum_next;
            s2_addr_reg <= s1_addr_reg;
            s2_pos_reg  <= s1_pos_reg;
        end
        if (s2_valid_reg)
        begin
            s3_grey_reg <= s3_grey_next;
            s3_addr_reg <= s2_addr_reg;
            s3_pos_reg  <= s2_pos_reg;
        end
        if (s3_valid_reg)
        begin
            fwd_data_reg <= wr_data;
            s4_pos_reg   <= s3_pos_reg;
        end
    end

    assign s4_valid = s4_valid_reg;
    assign s4_pos   = s4_pos_reg;
    assign win      = win_reg;

endmodule

// ===== sv/gnmd_grad.sv =====
// ----------------------------------------------------------------------------
// gnmd_grad
// Masked absolute neighbour differences, maximum and contour value.
// ----------------------------------------------------------------------------
module gnmd_grad (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s4_valid,
    input  gnmd_pkg::pos_t s4_pos,
    input  gnmd_pkg::win_t win,
    output logic           push,
    output logic           drop,
    output gnmd_pkg::res_t res
);

    import gnmd_pkg::*;

    win_t diff_reg, diff_next;
    logic s5_valid_reg;
    logic s5_have_reg;
    logic s5_eof_reg;
    pix_t centre;
    pix_t v;
    logic skip;
    pix_t best;

    always_comb
    begin
        centre    = win[1][1];
        diff_next = '0;
        v         = '0;
        skip      = 1'b0;
        for (int dy = 0; dy < 3; dy++)
        begin
            for (int dx = 0; dx < 3; dx++)
            begin
                skip = (dy == 1 && dx == 1) || (dy == 0 && s4_pos.top) ||
                       (dy == 2 && s4_pos.bottom) || (dx == 0 && s4_pos.left) ||
                       (dx == 2 && s4_pos.right);
                v = win[dy][dx];
                diff_next[dy][dx] = skip ? '0 : ((v > centre) ? (v - centre) : (centre - v));
            end
        end
    end

    always_comb
    begin
        best = '0;
        for (int dy = 0; dy < 3; dy++)
        begin
            for (int dx = 0; dx < 3; dx++)
            begin
                if (diff_reg[dy][dx] > best)
                    best = diff_reg[dy][dx];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s5_valid_reg <= 1'b0;
        end
        else
        begin
            s5_valid_reg <= s4_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s4_valid)
        begin
            diff_reg    <= diff_next;
            s5_have_reg <= s4_pos.have;
            s5_eof_reg  <= s4_pos.eof;
        end
    end

    assign push        = s5_valid_reg && s5_have_reg;
    assign drop        = s5_valid_reg && !s5_have_reg;
    assign res.contour = pix_t'(PIX_MAX) - best;
    assign res.eof     = s5_eof_reg;

endmodule

// ===== sv/gnmd_out_fifo.sv =====
// ----------------------------------------------------------------------------
// gnmd_out_fifo
// Result queue with credit count over transactions still in the pipeline.
// ----------------------------------------------------------------------------
module gnmd_out_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           accept,
    input  logic           push,
    input  logic           drop,
    input  gnmd_pkg::res_t push_data,
    input  logic           pop_ready,
    output logic           pop_valid,
    output gnmd_pkg::res_t pop_data,
    output logic           room
);

    import gnmd_pkg::*;

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    res_t             entries_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] pend_reg, pend_next;
    logic             pop;

    assign pop_valid = (count_reg != '0);
    assign pop       = pop_valid && pop_ready;
    assign pop_data  = entries_reg[rd_ptr_reg];
    assign room      = (pend_reg < CNT_W'(FIFO_DEPTH));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        count_next = count_reg + CNT_W'(push) - CNT_W'(pop);
        pend_next  = pend_reg + CNT_W'(accept) - CNT_W'(drop) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            pend_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
            pend_reg   <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== sv/grey_neighbour_max_diff_edges_top.sv =====
// ----------------------------------------------------------------------------
// grey_neighbour_max_diff_edges_top
// 3x3 greyscale contour: 255 minus the largest absolute neighbour difference.
//
//   channel  | handshake            | payload
//   ---------+----------------------+--------------------------------------
//   cfg      | cfg_valid/cfg_ready  | cfg_index, cfg_data
//   pixel    | pix_valid/pix_ready  | red, green, blue, is_padding
//   result   | res_valid/res_ready  | contour_value, end_of_frame
//
// One pixel transaction per clock while pix_ready is high; the single line
// memory is read and written once per pixel, which sets that rate.
// A window completes one row plus one pixel later in the stream; its result is
// formed in the input, sum, grey, window and difference registers, then queued.
// The line memory is not cleared after reset; unwritten rows are masked.
// pix_ready drops once 8 transactions are in flight or queued for output.
// ----------------------------------------------------------------------------
module grey_neighbour_max_diff_edges_top #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [gnmd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [gnmd_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             pix_valid,
    output logic                             pix_ready,
    input  logic [gnmd_pkg::PIX_W-1:0]       red,
    input  logic [gnmd_pkg::PIX_W-1:0]       green,
    input  logic [gnmd_pkg::PIX_W-1:0]       blue,
    input  logic                             is_padding,
    output logic                             res_valid,
    input  logic                             res_ready,
    output logic [gnmd_pkg::PIX_W-1:0]       contour_value,
    output logic                             end_of_frame
);

    import gnmd_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);

    logic          accept;
    logic [CW-1:0] addr;
    pos_t          pos;
    logic          s4_valid;
    pos_t          s4_pos;
    win_t          win;
    logic          push;
    logic          drop;
    res_t          res;
    res_t          head;
    logic          room;

    assign accept    = pix_valid && pix_ready;
    assign pix_ready = room;

    gnmd_scan #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg_ready (cfg_ready),
        .advance   (accept),
        .addr      (addr),
        .pos       (pos)
    );

    gnmd_line_buf #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (accept),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .is_padding (is_padding),
        .addr       (addr),
        .pos        (pos),
        .s4_valid   (s4_valid),
        .s4_pos     (s4_pos),
        .win        (win)
    );

    gnmd_grad u_grad (
        .clk      (clk),
        .rst_n    (rst_n),
        .s4_valid (s4_valid),
        .s4_pos   (s4_pos),
        .win      (win),
        .push     (push),
        .drop     (drop),
        .res      (res)
    );

    gnmd_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .push      (push),
        .drop      (drop),
        .push_data (res),
        .pop_ready (res_ready),
        .pop_valid (res_valid),
        .pop_data  (head),
        .room      (room)
    );

    assign contour_value = head.contour;
    assign end_of_frame  = head.eof;

endmodule

// ===== sv/gnmd_checker.sv =====
// ----------------------------------------------------------------------------
// gnmd_checker
// Port-level properties of the grey neighbour contour block, bound to the top.
// ----------------------------------------------------------------------------
`include "grey_neighbour_max_diff_edges_top_defines.svh"

module gnmd_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       pix_valid,
    input logic                       pix_ready,
    input logic                       res_valid,
    input logic                       res_ready,
    input logic [gnmd_pkg::PIX_W-1:0] contour_value,
    input logic                       end_of_frame
);

    import gnmd_pkg::*;

    // hold the result while the consumer stalls
    `GNMD_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(contour_value) && $stable(end_of_frame), "result changed while stalled")

    // input backpressure only with results waiting
    `GNMD_ASSERT_NOW(a_stall_has_result, !pix_ready, res_valid, "pixel input stalled with no result queued")

    // fixed pipeline depth from pixel transaction to result
    `GNMD_ASSERT_NOW(a_result_latency, $rose(res_valid), $past(pix_valid && pix_ready, 6), "result appeared without a pixel transaction six cycles earlier")

endmodule

bind grey_neighbour_max_diff_edges_top gnmd_checker u_gnmd_checker (.*);
